@@ sv/utf8_glyph_layout_engine_assert.svh @@
// assertion macros for the glyph layout engine checker
// holds only macro definitions, no dependencies
`ifndef UTF8_GLYPH_LAYOUT_ENGINE_ASSERT_SVH
`define UTF8_GLYPH_LAYOUT_ENGINE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define UGL_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define UGL_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ sv/ugle_pkg.sv @@
// shared types and constants for the glyph layout engine
// no dependencies
`timescale 1ns / 1ps
package ugle_pkg;
  localparam int GlyphEntries = 256;
  localparam int KernEntries  = 256;

  localparam logic [1:0] ModeText  = 2'd0;
  localparam logic [1:0] ModeGlyph = 2'd1;
  localparam logic [1:0] ModeKern  = 2'd2;
  localparam logic [1:0] ModeReset = 2'd3;

  localparam logic [2:0] KindQuad     = 3'd0;
  localparam logic [2:0] KindFallback = 3'd1;
  localparam logic [2:0] KindWriteOk  = 3'd2;
  localparam logic [2:0] KindFull     = 3'd3;
  localparam logic [2:0] KindNoGlyph  = 3'd4;

  localparam logic [11:0] LineHeightReset = 12'd16;
  localparam logic [20:0] CodeNewline     = 21'd10;

  // register indexes
  localparam logic CfgLineHeight = 1'b0;
  localparam logic CfgMonospace  = 1'b1;

  // classified commands from the front part
  typedef enum logic [1:0] {
    OP_GLYPH = 2'd0,
    OP_KERN  = 2'd1,
    OP_CHAR  = 2'd2,
    OP_NEWSTR = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [20:0] code;
    logic [20:0] prior;
    logic [47:0] rect;
    logic [35:0] metrics;
    logic [11:0] kern;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GSCAN,
    ST_KSCAN,
    ST_READ,
    ST_EMIT
  } back_state_e;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage

@@ sv/ugle_front.sv @@
// front part: utf-8 decoding and command classification
// depends on ugle_pkg
`timescale 1ns / 1ps
module ugle_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          text_byte_i,
  input  logic [20:0]         code_point_i,
  input  logic [20:0]         prior_code_i,
  input  logic [47:0]         rect_i,
  input  logic [35:0]         metrics_i,
  input  logic [11:0]         kern_i,
  output logic                push_o,
  output ugle_pkg::cmd_t      cmd_o
);
  logic [1:0]  pend_q, pend_d;
  logic [20:0] acc_q, acc_d;
  logic [20:0] cont;

  assign cont = {acc_q[14:0], text_byte_i[5:0]};

  // decode and classify
  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    push_o = 1'b0;
    cmd_o.op      = ugle_pkg::OP_CHAR;
    cmd_o.code    = code_point_i;
    cmd_o.prior   = prior_code_i;
    cmd_o.rect    = rect_i;
    cmd_o.metrics = metrics_i;
    cmd_o.kern    = kern_i;
    if (take_i) begin
      unique case (mode_i)
        ugle_pkg::ModeGlyph: begin
          push_o = 1'b1;
          cmd_o.op = ugle_pkg::OP_GLYPH;
        end
        ugle_pkg::ModeKern: begin
          push_o = 1'b1;
          cmd_o.op = ugle_pkg::OP_KERN;
        end
        ugle_pkg::ModeReset: begin
          push_o = 1'b1;
          cmd_o.op = ugle_pkg::OP_NEWSTR;
          pend_d = '0;
          acc_d  = '0;
        end
        default: begin
          if (pend_q != 2'd0) begin
            acc_d  = cont;
            pend_d = pend_q - 2'd1;
            if (pend_q == 2'd1) begin
              push_o = 1'b1;
              cmd_o.code = cont;
            end
          end else if (!text_byte_i[7] || text_byte_i[7:6] == 2'b10) begin
            push_o = 1'b1;
            cmd_o.code = {13'd0, text_byte_i};
          end else if (text_byte_i[7:5] == 3'b110) begin
            acc_d  = {16'd0, text_byte_i[4:0]};
            pend_d = 2'd1;
          end else if (text_byte_i[7:4] == 4'b1110) begin
            acc_d  = {17'd0, text_byte_i[3:0]};
            pend_d = 2'd2;
          end else begin
            acc_d  = {18'd0, text_byte_i[2:0]};
            pend_d = 2'd3;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
    end else begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end
endmodule

@@ sv/ugle_queue.sv @@
// two-entry command queue between front and back parts
// depends on ugle_pkg
`timescale 1ns / 1ps
module ugle_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ugle_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output logic           not_empty_o,
  output logic           full_o,
  output ugle_pkg::cmd_t head_o
);
  ugle_pkg::cmd_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign not_empty_o = cnt_q != 2'd0;
  assign full_o      = cnt_q == 2'd2;
  assign head_o      = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

@@ sv/ugle_back.sv @@
// back part: table store, search, kerning, pen and quad output
// depends on ugle_pkg
`timescale 1ns / 1ps
module ugle_back #(
  parameter int GLYPH_ENTRIES = ugle_pkg::GlyphEntries,
  parameter int KERN_ENTRIES  = ugle_pkg::KernEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  ugle_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                busy_o,
  input  logic [11:0]         line_height_i,
  input  logic                monospace_i,
  output logic                valid_o,
  output logic [2:0]          kind_o,
  output logic signed [15:0]  dest_x_o,
  output logic signed [15:0]  dest_y_o,
  output logic [11:0]         src_x_o,
  output logic [11:0]         src_y_o,
  output logic [11:0]         quad_w_o,
  output logic [11:0]         quad_h_o
);
  localparam int GW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int KW = (KERN_ENTRIES > 1) ? $clog2(KERN_ENTRIES) : 1;
  localparam int GC = $clog2(GLYPH_ENTRIES + 1);
  localparam int KC = $clog2(KERN_ENTRIES + 1);

  // memories, one scan port each, read data registered
  logic [20:0] gkey_mem [GLYPH_ENTRIES];
  logic [83:0] gdat_mem [GLYPH_ENTRIES];
  logic [41:0] kkey_mem [KERN_ENTRIES];
  logic [11:0] kval_mem [KERN_ENTRIES];

  ugle_pkg::back_state_e st_q, st_d;
  ugle_pkg::cmd_t cmd_q;
  logic [GC-1:0] gcnt_q;
  logic [KC-1:0] kcnt_q;
  logic [GC:0]   gi_q, gi_d;
  logic [KC:0]   ki_q, ki_d;
  logic          scan_q, scan_d;
  logic [20:0]   gkey_rd_q;
  logic [83:0]   gdat_rd_q;
  logic [41:0]   kkey_rd_q;
  logic [11:0]   kval_rd_q;
  logic          found_q, found_d;
  logic [GW-1:0] idx_q, idx_d;
  logic [11:0]   wide_q;
  logic signed [15:0] pen_x_q, pen_y_q;
  logic [20:0]   prev_q;
  logic          gread, kread, gwr, kwr;
  logic [GW-1:0] gaddr;
  logic [KW-1:0] kaddr;
  logic          gfull, kfull;
  logic signed [15:0] pen_x_d, pen_y_d;
  logic [20:0]   prev_d;
  logic [11:0]   wide_d;
  logic [GC-1:0] gcnt_d;
  logic [KC-1:0] kcnt_d;
  logic          out_v_d;
  logic [2:0]    out_k_d;
  logic signed [15:0] out_dx_d, out_dy_d;
  logic [47:0]   out_r_d;
  logic [11:0]   adv;
  logic signed [11:0] offx, offy;

  assign gfull = gcnt_q == GC'(GLYPH_ENTRIES);
  assign kfull = kcnt_q == KC'(KERN_ENTRIES);
  assign offx  = gdat_rd_q[59:48];
  assign offy  = gdat_rd_q[71:60];
  assign adv   = gdat_rd_q[83:72];
  assign busy_o = st_q != ugle_pkg::ST_IDLE;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (gwr) begin
      gkey_mem[gaddr] <= cmd_q.code;
      gdat_mem[gaddr] <= {cmd_q.metrics, cmd_q.rect};
    end
    if (gread) begin
      gkey_rd_q <= gkey_mem[gaddr];
      gdat_rd_q <= gdat_mem[gaddr];
    end
    if (kwr) begin
      kkey_mem[kaddr] <= {cmd_q.code, cmd_q.prior};
      kval_mem[kaddr] <= cmd_q.kern;
    end
    if (kread) begin
      kkey_rd_q <= kkey_mem[kaddr];
      kval_rd_q <= kval_mem[kaddr];
    end
  end

  // sequencer: linear search one entry per cycle
  always_comb begin
    st_d = st_q; gi_d = gi_q; ki_d = ki_q; scan_d = scan_q;
    found_d = found_q; idx_d = idx_q;
    pop_o = 1'b0; gread = 1'b0; kread = 1'b0; gwr = 1'b0; kwr = 1'b0;
    gaddr = gi_q[GW-1:0]; kaddr = ki_q[KW-1:0];
    pen_x_d = pen_x_q; pen_y_d = pen_y_q; prev_d = prev_q;
    wide_d = wide_q; gcnt_d = gcnt_q; kcnt_d = kcnt_q;
    out_v_d = 1'b0; out_k_d = ugle_pkg::KindQuad;
    out_dx_d = '0; out_dy_d = '0; out_r_d = '0;
    unique case (st_q)
      ugle_pkg::ST_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          gi_d = '0; ki_d = '0; scan_d = 1'b0; found_d = 1'b0; idx_d = '0;
          unique case (cmd_i.op)
            ugle_pkg::OP_NEWSTR: begin
              pen_x_d = '0;
              pen_y_d = -$signed({4'd0, line_height_i});
              prev_d = '0;
            end
            ugle_pkg::OP_KERN: st_d = ugle_pkg::ST_KSCAN;
            ugle_pkg::OP_GLYPH: st_d = ugle_pkg::ST_GSCAN;
            default: begin
              if (cmd_i.code == ugle_pkg::CodeNewline) begin
                pen_x_d = '0;
                pen_y_d = ugle_pkg::sat16($signed({pen_y_q[15], pen_y_q[15], pen_y_q})
                          + $signed({6'd0, line_height_i}));
              end else if (gcnt_q == '0) begin
                out_v_d = 1'b1; out_k_d = ugle_pkg::KindNoGlyph;
              end else st_d = ugle_pkg::ST_GSCAN;
            end
          endcase
        end
      end
      ugle_pkg::ST_GSCAN: begin
        // compare the entry read last cycle
        if (scan_q && gkey_rd_q == cmd_q.code) begin
          found_d = 1'b1; idx_d = GW'(gi_q - 1'b1);
        end
        if (found_d || gi_q == {1'b0, gcnt_q}) begin
          scan_d = 1'b0;
          if (cmd_q.op == ugle_pkg::OP_GLYPH) begin
            st_d = ugle_pkg::ST_IDLE; out_v_d = 1'b1;
            if (!found_d && gfull) out_k_d = ugle_pkg::KindFull;
            else begin
              out_k_d = ugle_pkg::KindWriteOk;
              gwr = 1'b1;
              gaddr = found_d ? idx_d : gcnt_q[GW-1:0];
              if (!found_d) gcnt_d = gcnt_q + 1'b1;
              if (cmd_q.metrics[35:24] > wide_q) wide_d = cmd_q.metrics[35:24];
            end
          end else begin
            // read the chosen glyph (fallback index zero), then kern search unless monospace
            gread = 1'b1; gaddr = idx_d;
            st_d = monospace_i ? ugle_pkg::ST_READ : ugle_pkg::ST_KSCAN;
          end
        end else begin
          gread = 1'b1; scan_d = 1'b1; gi_d = gi_q + 1'b1;
        end
      end
      ugle_pkg::ST_KSCAN: begin
        if (cmd_q.op == ugle_pkg::OP_KERN) begin
          if (scan_q && kkey_rd_q == {cmd_q.code, cmd_q.prior}) begin
            found_d = 1'b1; idx_d = '0;
          end
          if (found_d || ki_q == {1'b0, kcnt_q}) begin
            st_d = ugle_pkg::ST_IDLE; out_v_d = 1'b1;
            if (!found_d && kfull) out_k_d = ugle_pkg::KindFull;
            else begin
              out_k_d = ugle_pkg::KindWriteOk;
              kwr = 1'b1;
              kaddr = found_d ? KW'(ki_q - 1'b1) : kcnt_q[KW-1:0];
              if (!found_d) kcnt_d = kcnt_q + 1'b1;
            end
          end else begin
            kread = 1'b1; scan_d = 1'b1; ki_d = ki_q + 1'b1;
          end
        end else begin
          // kerning for a character; key uses the glyph's own code
          if (scan_q && kkey_rd_q == {gkey_rd_q, prev_q}) begin
            pen_x_d = ugle_pkg::sat16($signed({pen_x_q[15], pen_x_q[15], pen_x_q})
                      + $signed({{6{kval_rd_q[11]}}, kval_rd_q}));
            st_d = ugle_pkg::ST_READ; scan_d = 1'b0;
          end else if (ki_q == {1'b0, kcnt_q}) begin
            st_d = ugle_pkg::ST_READ; scan_d = 1'b0;
          end else begin
            kread = 1'b1; scan_d = 1'b1; ki_d = ki_q + 1'b1;
          end
        end
      end
      ugle_pkg::ST_READ: begin
        st_d = ugle_pkg::ST_EMIT;
        out_v_d = 1'b1;
        out_k_d = found_q ? ugle_pkg::KindQuad : ugle_pkg::KindFallback;
        out_dx_d = ugle_pkg::sat16($signed({pen_x_q[15], pen_x_q[15], pen_x_q})
                   + $signed({{6{offx[11]}}, offx}));
        out_dy_d = ugle_pkg::sat16($signed({pen_y_q[15], pen_y_q[15], pen_y_q})
                   + $signed({{6{offy[11]}}, offy}));
        out_r_d = gdat_rd_q[47:0];
      end
      ugle_pkg::ST_EMIT: begin
        st_d = ugle_pkg::ST_IDLE;
        pen_x_d = ugle_pkg::sat16($signed({pen_x_q[15], pen_x_q[15], pen_x_q})
                  + $signed({6'd0, (monospace_i && wide_q > adv) ? wide_q : adv}));
        prev_d = cmd_q.code;
      end
      default: st_d = ugle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ugle_pkg::ST_IDLE && avail_i) cmd_q <= cmd_i;
    kind_o <= out_k_d;
    dest_x_o <= out_dx_d;
    dest_y_o <= out_dy_d;
    src_x_o <= out_r_d[11:0];
    src_y_o <= out_r_d[23:12];
    quad_w_o <= out_r_d[35:24];
    quad_h_o <= out_r_d[47:36];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ugle_pkg::ST_IDLE;
      gi_q <= '0; ki_q <= '0; scan_q <= 1'b0; found_q <= 1'b0; idx_q <= '0;
      gcnt_q <= '0; kcnt_q <= '0; wide_q <= '0;
      pen_x_q <= '0; pen_y_q <= -16'sd16; prev_q <= '0;
      valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      gi_q <= gi_d; ki_q <= ki_d; scan_q <= scan_d; found_q <= found_d; idx_q <= idx_d;
      gcnt_q <= gcnt_d; kcnt_q <= kcnt_d; wide_q <= wide_d;
      pen_x_q <= pen_x_d; pen_y_q <= pen_y_d; prev_q <= prev_d;
      valid_o <= out_v_d;
    end
  end
endmodule

@@ sv/utf8_glyph_layout_engine.sv @@
// Text layout engine for a bitmap font: utf-8 decode, glyph and kerning lookup
// Depends on ugle_pkg, ugle_front, ugle_queue, ugle_back
//
// Usage: drive an item with start high while busy is low. mode 0 takes a
// text byte, mode 1 writes a glyph, mode 2 writes a kerning pair, mode 3
// starts a new string. Results appear for one cycle with valid_o high; the
// receiver cannot hold them off. Registers are written via cfg_we_i,
// cfg_idx_i and cfg_data_i (0 line height, 1 monospace); the user must write
// them only while idle, as the block does not enforce it. Lead and mid
// sequence bytes only update the decoder and keep busy low, so the next item
// can follow at the next edge. New string, newline and a character with no
// glyph loaded are handled by the back part without a table scan. A character
// scans the glyph table and, unless monospace is set, the kerning table, one
// entry per cycle through the single read port of each; a match ends a scan
// early, and monospace skips the kerning scan. A table write scans its table
// for the key before it writes and holds busy while it scans.
// Reset clears counts, pen to (0, -16), decoder state; tables are undefined
// until written and need no clearing.
`timescale 1ns / 1ps
module utf8_glyph_layout_engine #(
  parameter int GLYPH_ENTRIES = ugle_pkg::GlyphEntries,
  parameter int KERN_ENTRIES  = ugle_pkg::KernEntries
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         text_byte_i,
  input  logic [20:0]        code_point_i,
  input  logic [20:0]        prior_code_i,
  input  logic [11:0]        atlas_x_i,
  input  logic [11:0]        atlas_y_i,
  input  logic [11:0]        glyph_width_i,
  input  logic [11:0]        glyph_height_i,
  input  logic signed [11:0] draw_offset_x_i,
  input  logic signed [11:0] draw_offset_y_i,
  input  logic [11:0]        pen_advance_i,
  input  logic signed [11:0] kern_amount_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [11:0]        cfg_data_i,
  output logic               valid_o,
  output logic [2:0]         kind_o,
  output logic signed [15:0] dest_x_o,
  output logic signed [15:0] dest_y_o,
  output logic [11:0]        src_x_o,
  output logic [11:0]        src_y_o,
  output logic [11:0]        quad_w_o,
  output logic [11:0]        quad_h_o
);
  logic [11:0] lh_q;
  logic        mono_q;
  logic        push, pop, nonempty, full, back_busy, take;
  ugle_pkg::cmd_t fcmd, head;

  assign take = start && !busy;
  assign busy = full || nonempty || back_busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lh_q <= ugle_pkg::LineHeightReset;
      mono_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ugle_pkg::CfgLineHeight: lh_q <= cfg_data_i;
        default: mono_q <= cfg_data_i[0];
      endcase
    end
  end

  ugle_front u_front (
    .clk_i, .rst_ni, .take_i(take), .mode_i, .text_byte_i, .code_point_i,
    .prior_code_i,
    .rect_i({glyph_height_i, glyph_width_i, atlas_y_i, atlas_x_i}),
    .metrics_i({pen_advance_i, draw_offset_y_i, draw_offset_x_i}),
    .kern_i(kern_amount_i), .push_o(push), .cmd_o(fcmd)
  );

  ugle_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(fcmd), .pop_i(pop),
    .not_empty_o(nonempty), .full_o(full), .head_o(head)
  );

  ugle_back #(.GLYPH_ENTRIES(GLYPH_ENTRIES), .KERN_ENTRIES(KERN_ENTRIES)) u_back (
    .clk_i, .rst_ni, .avail_i(nonempty), .cmd_i(head), .pop_o(pop),
    .busy_o(back_busy), .line_height_i(lh_q), .monospace_i(mono_q),
    .valid_o, .kind_o, .dest_x_o, .dest_y_o, .src_x_o, .src_y_o,
    .quad_w_o, .quad_h_o
  );
endmodule

@@ sv/ugle_checker.sv @@
// port-level checker for the glyph layout engine, bound to the top level
// depends on ugle_pkg and utf8_glyph_layout_engine_assert.svh
`timescale 1ns / 1ps
`include "utf8_glyph_layout_engine_assert.svh"
module ugle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  mode_i,
  input logic        valid_o,
  input logic [2:0]  kind_o,
  input logic [15:0] dest_x_o,
  input logic [11:0] quad_w_o
);
  // kind codes stay in range
  `UGL_ASSERT_IMP(a_kind, clk_i, rst_ni, valid_o, kind_o <= ugle_pkg::KindNoGlyph)
  // write, full and no-glyph results carry zero dest_x and quad width
  `UGL_ASSERT_IMP(a_zero, clk_i, rst_ni,
    valid_o && kind_o >= ugle_pkg::KindWriteOk, dest_x_o == '0 && quad_w_o == '0)
  // an accepted table write keeps the block busy next cycle
  `UGL_ASSERT_NXT(a_wbusy, clk_i, rst_ni,
    start && !busy && (mode_i == ugle_pkg::ModeGlyph || mode_i == ugle_pkg::ModeKern), busy)
endmodule

bind utf8_glyph_layout_engine ugle_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .mode_i, .valid_o, .kind_o, .dest_x_o, .quad_w_o
);
